// ===== src/dbwu_pkg.sv =====
// shared types and constants of the debug breakpoint and watchpoint unit
// no dependencies; imported by every module of the block
`default_nettype none

package dbwu_pkg;

  localparam int NumBp      = 4;   // breakpoint slots checked, 1..4
  localparam int NumWp      = 4;   // watchpoint slots checked, 1..4
  localparam int NumBpRegs  = 4;   // breakpoint registers in the register map
  localparam int NumWpRegs  = 4;   // watchpoint registers in the register map
  localparam int CntW       = 32;
  localparam int CfgIdxW    = 4;
  localparam int CfgDataW   = 25;
  localparam int BpRegW     = 18;
  localparam int WpRegW     = 25;
  localparam int CfgBpBase  = 0;
  localparam int CfgWpBase  = CfgBpBase + NumBpRegs;

  // breakpoint register fields
  localparam int BpValidBit = 17;
  localparam int BpEnBit    = 16;

  // watchpoint register fields
  localparam int WpValidBit = 24;

  typedef enum logic [1:0] {
    TgtMem = 2'd0,
    TgtReg = 2'd1,
    TgtAcc = 2'd2,
    TgtNone = 2'd3
  } wp_target_e;

  typedef enum logic [1:0] {
    ModeChange = 2'd0,
    ModeWrite  = 2'd1,
    ModeRead   = 2'd2,
    ModeNone   = 2'd3
  } wp_mode_e;

  typedef struct packed {
    logic        kind;
    logic [15:0] address;
    logic [3:0]  reg_id;
    logic [7:0]  data_value;
    logic        wr_access;
  } in_item_t;

  typedef struct packed {
    logic            bp_hit;
    logic [1:0]      bp_slot;
    logic [CntW-1:0] bp_slot_hits;
    logic [CntW-1:0] bp_total_hits;
    logic [3:0]      wp_trigger_mask;
    logic [CntW-1:0] wp_total_triggers;
    logic            wp_stop;
  } out_item_t;

  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  // per-event control from the top level to the matchers
  typedef struct packed {
    logic upd;       // event is processed this cycle
    logic is_fetch;  // event is a fetch check
  } evt_ctrl_t;

  typedef struct packed {
    logic            hit;
    logic [1:0]      slot;
    logic [CntW-1:0] slot_hits;
    logic [CntW-1:0] total;
  } bp_res_t;

  typedef struct packed {
    logic [3:0]      mask;
    logic [CntW-1:0] total;
  } wp_res_t;

endpackage

`default_nettype wire

// ===== src/dbwu_bp.sv =====
// breakpoint slots: address compare, lowest-slot priority and hit counters
// depends on dbwu_pkg
`default_nettype none

module dbwu_bp
  import dbwu_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_wr_t   cfg_i,
  input  wire evt_ctrl_t ctrl_i,
  input  wire logic [15:0] pc_i,
  output bp_res_t        res_o
);

  logic [BpRegW-1:0] slot_q  [NumBp];
  logic [CntW-1:0]   count_q [NumBp];
  logic [CntW-1:0]   total_q;
  logic [NumBp-1:0]  match;
  logic              hit;
  logic [1:0]        win;
  logic [CntW-1:0]   win_cnt;

  always_comb begin
    hit     = 1'b0;
    win     = '0;
    win_cnt = '0;
    for (int i = 0; i < NumBp; i++) begin
      match[i] = ctrl_i.is_fetch && slot_q[i][BpValidBit] && slot_q[i][BpEnBit] &&
                 (slot_q[i][15:0] == pc_i);
    end
    // scan downward so the lowest matching slot wins
    for (int i = NumBp - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        win     = 2'(i);
        win_cnt = count_q[i] + 1'b1;
      end
    end
  end

  always_comb begin
    res_o.hit       = hit;
    res_o.slot      = win;
    res_o.slot_hits = win_cnt;
    res_o.total     = total_q + CntW'(hit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      for (int i = 0; i < NumBp; i++) begin
        slot_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NumBp; i++) begin
        if (cfg_i.we && cfg_i.idx == CfgIdxW'(CfgBpBase + i)) begin
          slot_q[i] <= cfg_i.data[BpRegW-1:0];
        end
        if (ctrl_i.upd && hit && win == 2'(i)) begin
          count_q[i] <= win_cnt;
        end
      end
      if (ctrl_i.upd && hit) begin
        total_q <= res_o.total;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/dbwu_wp.sv =====
// watchpoint slots: address, register or accumulator select, mode check,
// last-value tracking and trigger total; depends on dbwu_pkg
`default_nettype none

module dbwu_wp
  import dbwu_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_wr_t   cfg_i,
  input  wire evt_ctrl_t ctrl_i,
  input  wire in_item_t  item_i,
  output wp_res_t        res_o
);

  logic [WpRegW-1:0] slot_q [NumWp];
  logic [7:0]        last_q [NumWp];
  logic [CntW-1:0]   total_q;
  logic [NumWp-1:0]  sel;
  logic [NumWp-1:0]  trig;
  logic [2:0]        n_trig;
  wp_target_e        tgt  [NumWp];
  wp_mode_e          mode [NumWp];

  always_comb begin
    n_trig = '0;
    for (int i = 0; i < NumWp; i++) begin
      tgt[i]  = wp_target_e'(slot_q[i][23:22]);
      mode[i] = wp_mode_e'(slot_q[i][21:20]);
      sel[i]  = 1'b0;
      trig[i] = 1'b0;
      if (!ctrl_i.is_fetch && slot_q[i][WpValidBit]) begin
        unique case (tgt[i])
          TgtMem: begin
            sel[i] = (slot_q[i][19:4] == item_i.address);
            case (mode[i])
              ModeChange: trig[i] = sel[i] && (last_q[i] != item_i.data_value);
              ModeWrite:  trig[i] = sel[i] && item_i.wr_access;
              ModeRead:   trig[i] = sel[i] && !item_i.wr_access;
              default:    trig[i] = 1'b0;
            endcase
          end
          TgtReg: begin
            sel[i]  = (slot_q[i][3:0] == item_i.reg_id);
            trig[i] = sel[i] && mode[i] == ModeChange &&
                      (last_q[i] != item_i.data_value);
          end
          TgtAcc: begin
            sel[i]  = 1'b1;
            trig[i] = mode[i] == ModeChange && (last_q[i] != item_i.data_value);
          end
          default: begin
            sel[i]  = 1'b0;
            trig[i] = 1'b0;
          end
        endcase
      end
      n_trig = n_trig + 3'(trig[i]);
    end
  end

  always_comb begin
    res_o.mask  = 4'(trig);
    res_o.total = total_q + CntW'(n_trig);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      for (int i = 0; i < NumWp; i++) begin
        slot_q[i] <= '0;
        last_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NumWp; i++) begin
        if (cfg_i.we && cfg_i.idx == CfgIdxW'(CfgWpBase + i)) begin
          slot_q[i] <= cfg_i.data[WpRegW-1:0];
          last_q[i] <= '0;
        end else if (ctrl_i.upd && sel[i]) begin
          last_q[i] <= item_i.data_value;
        end
      end
      if (ctrl_i.upd) begin
        total_q <= res_o.total;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/debug_breakpoint_watchpoint_unit.sv =====
// top level of the debug trigger unit: input and result registers, handshakes
// depends on dbwu_pkg, dbwu_bp and dbwu_wp
`default_nettype none

// Debug trigger unit. Each accepted event beat (fetch or data) gives exactly
// one result beat. An event is registered on entry, checked combinationally
// against all breakpoint or watchpoint slots, and its result is loaded into
// an output register; one event is taken every cycle while out_stall_i is
// low. Throughput is set only by the result register, which holds while
// out_stall_i is high. Configuration writes (indexes 0-3 breakpoints, 4-7
// watchpoints) take effect on the next cycle and are expected only while
// no event is in flight.

module debug_breakpoint_watchpoint_unit
  import dbwu_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_item_t            in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_item_t                out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  logic      in_valid_q, in_valid_d;
  in_item_t  in_item_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;
  logic      advance, proc_en, load;
  cfg_wr_t   cfg;
  evt_ctrl_t ctrl;
  bp_res_t   bp_res;
  wp_res_t   wp_res;

  assign advance    = !out_valid_q || !out_stall_i;
  assign proc_en    = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign load       = in_valid_i && !in_stall_o;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  assign ctrl.upd      = proc_en;
  assign ctrl.is_fetch = !in_item_q.kind;

  dbwu_bp u_bp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .ctrl_i (ctrl),
    .pc_i   (in_item_q.address),
    .res_o  (bp_res)
  );

  dbwu_wp u_wp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .ctrl_i (ctrl),
    .item_i (in_item_q),
    .res_o  (wp_res)
  );

  always_comb begin
    out_item_d.bp_hit            = bp_res.hit;
    out_item_d.bp_slot           = bp_res.slot;
    out_item_d.bp_slot_hits      = bp_res.slot_hits;
    out_item_d.bp_total_hits     = bp_res.total;
    out_item_d.wp_trigger_mask   = wp_res.mask;
    out_item_d.wp_total_triggers = wp_res.total;
    out_item_d.wp_stop           = |wp_res.mask;
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (load) begin
      in_valid_d = 1'b1;
    end else if (proc_en) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (proc_en) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      in_item_q <= in_data_i;
    end
    if (proc_en) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

endmodule

`default_nettype wire
